// ===== rtl/tcq_pkg.sv =====
// Shared types, codes and default sizes for the two-class oldest-first queue block.
package tcq_pkg;

    localparam int TCQ_QUEUE_DEPTH = 16;
    localparam int TCQ_TAG_WIDTH   = 32;
    localparam int STAMP_W         = 32;
    localparam int FIELD_W         = 32;
    localparam int CMD_W           = 3;
    localparam int STATUS_W        = 2;

    // command codes carried in s_tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ_A   = 3'd0,
        CMD_ENQ_B   = 3'd1,
        CMD_DEQ_A   = 3'd2,
        CMD_DEQ_B   = 3'd3,
        CMD_DEQ_OLD = 3'd4
    } cmd_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // class codes
    localparam logic CLASS_A = 1'b0;
    localparam logic CLASS_B = 1'b1;

    // per-queue control from the command decoder
    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctrl_t;

    // per-queue status back to the command decoder
    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

    // one result item
    typedef struct packed {
        status_t              status;
        logic                 served_class;
        logic [FIELD_W-1:0]   payload;
        logic [STAMP_W-1:0]   stamp;
    } result_t;

endpackage

// ===== rtl/tcq_cell.sv =====
// One storage cell of a queue row: loads a new entry or takes its neighbour's on a pop.
module tcq_cell #(
    parameter int ENTRY_W = 64
) (
    input  logic               aclk,
    input  logic               shift_en,
    input  logic               load_en,
    input  logic [ENTRY_W-1:0] load_data,
    input  logic [ENTRY_W-1:0] shift_in,
    output logic [ENTRY_W-1:0] data_out
);

    logic [ENTRY_W-1:0] data_reg;
    logic [ENTRY_W-1:0] data_next;

    // pop moves the row one place towards the head; push fills the first free cell
    always_comb begin
        data_next = data_reg;
        if (shift_en) begin
            data_next = shift_in;
        end else if (load_en) begin
            data_next = load_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

// ===== rtl/tcq_row.sv =====
// One queue: a row of cells with the head in cell 0 and an occupancy count.
module tcq_row #(
    parameter int DEPTH   = tcq_pkg::TCQ_QUEUE_DEPTH,
    parameter int ENTRY_W = tcq_pkg::TCQ_TAG_WIDTH + tcq_pkg::STAMP_W
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  tcq_pkg::queue_ctrl_t       ctrl,
    input  logic [ENTRY_W-1:0]         push_data,
    output logic [ENTRY_W-1:0]         head_data,
    output tcq_pkg::queue_stat_t       stat,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int CNT_W = $clog2(DEPTH+1);

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [ENTRY_W-1:0] cell_data [DEPTH];
    logic               pop_ok;
    logic               push_ok;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign pop_ok     = ctrl.pop && !stat.empty;
    assign push_ok    = ctrl.push && !stat.full;

    // the row of cells
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [ENTRY_W-1:0] from_right;
        if (i == DEPTH - 1) begin : g_last
            assign from_right = cell_data[i];
        end else begin : g_mid
            assign from_right = cell_data[i+1];
        end
        tcq_cell #(
            .ENTRY_W (ENTRY_W)
        ) u_cell (
            .aclk      (aclk),
            .shift_en  (pop_ok),
            .load_en   (push_ok && (count_reg == CNT_W'(i))),
            .load_data (push_data),
            .shift_in  (from_right),
            .data_out  (cell_data[i])
        );
    end

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (push_ok) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop_ok) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign head_data = cell_data[0];
    assign count     = count_reg;

endmodule

// ===== rtl/two_class_fifo_oldest_dequeue.sv =====
// Two-class queue block: class A and class B queues, with an oldest-head dequeue.
// A result item is registered and presented in the cycle after its command item is accepted.
// Throughput: one command item per cycle, set by the head-cell stamp compare feeding
// the output register; s_tready holds low only while a result waits on m_tready.
// Reset (aresetn low, synchronous): both queue counts and the output valid clear;
// cell contents are not reset and are only read once written.
module two_class_fifo_oldest_dequeue #(
    parameter int QUEUE_DEPTH = tcq_pkg::TCQ_QUEUE_DEPTH,
    parameter int TAG_WIDTH   = tcq_pkg::TCQ_TAG_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] payload, [63:32] arrival_stamp
    input  logic [2:0]  s_tuser,   // [2:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] payload_out, [63:32] stamp_out
    output logic [2:0]  m_tuser    // [1:0] status, [2] served_class
);

    localparam int ENTRY_W = TAG_WIDTH + tcq_pkg::STAMP_W;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH+1);

    logic                  s_fire;
    logic [ENTRY_W-1:0]    push_data;
    logic [ENTRY_W-1:0]    head_a;
    logic [ENTRY_W-1:0]    head_b;
    logic [CNT_W-1:0]      count_a;
    logic [CNT_W-1:0]      count_b;
    tcq_pkg::queue_ctrl_t  ctrl_a;
    tcq_pkg::queue_ctrl_t  ctrl_b;
    tcq_pkg::queue_stat_t  stat_a;
    tcq_pkg::queue_stat_t  stat_b;
    tcq_pkg::result_t      res;
    tcq_pkg::result_t      res_reg;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  take_b;

    assign s_tready  = !out_valid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign push_data = {s_tdata[63:32], s_tdata[TAG_WIDTH-1:0]};

    // the two queues
    tcq_row #(
        .DEPTH   (QUEUE_DEPTH),
        .ENTRY_W (ENTRY_W)
    ) u_row_a (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl_a),
        .push_data (push_data),
        .head_data (head_a),
        .stat      (stat_a),
        .count     (count_a)
    );

    tcq_row #(
        .DEPTH   (QUEUE_DEPTH),
        .ENTRY_W (ENTRY_W)
    ) u_row_b (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl_b),
        .push_data (push_data),
        .head_data (head_b),
        .stat      (stat_b),
        .count     (count_b)
    );

    // oldest rule: B only when A is empty or A's stamp is strictly greater
    assign take_b = stat_a.empty ||
                    (!stat_b.empty && (head_a[ENTRY_W-1:TAG_WIDTH] > head_b[ENTRY_W-1:TAG_WIDTH]));

    // command decode and result
    always_comb begin
        ctrl_a           = '0;
        ctrl_b           = '0;
        res              = '0;
        res.status       = tcq_pkg::ST_OK;
        unique case (s_tuser)
            tcq_pkg::CMD_ENQ_A: begin
                ctrl_a.push = s_fire;
                if (stat_a.full) res.status = tcq_pkg::ST_FULL;
            end
            tcq_pkg::CMD_ENQ_B: begin
                ctrl_b.push = s_fire;
                if (stat_b.full) res.status = tcq_pkg::ST_FULL;
            end
            tcq_pkg::CMD_DEQ_A: begin
                if (stat_a.empty) begin
                    res.status = tcq_pkg::ST_EMPTY;
                end else begin
                    ctrl_a.pop       = s_fire;
                    res.served_class = tcq_pkg::CLASS_A;
                    res.payload      = tcq_pkg::FIELD_W'(head_a[TAG_WIDTH-1:0]);
                    res.stamp        = head_a[ENTRY_W-1:TAG_WIDTH];
                end
            end
            tcq_pkg::CMD_DEQ_B: begin
                if (stat_b.empty) begin
                    res.status = tcq_pkg::ST_EMPTY;
                end else begin
                    ctrl_b.pop       = s_fire;
                    res.served_class = tcq_pkg::CLASS_B;
                    res.payload      = tcq_pkg::FIELD_W'(head_b[TAG_WIDTH-1:0]);
                    res.stamp        = head_b[ENTRY_W-1:TAG_WIDTH];
                end
            end
            tcq_pkg::CMD_DEQ_OLD: begin
                if (stat_a.empty && stat_b.empty) begin
                    res.status = tcq_pkg::ST_EMPTY;
                end else if (take_b) begin
                    ctrl_b.pop       = s_fire;
                    res.served_class = tcq_pkg::CLASS_B;
                    res.payload      = tcq_pkg::FIELD_W'(head_b[TAG_WIDTH-1:0]);
                    res.stamp        = head_b[ENTRY_W-1:TAG_WIDTH];
                end else begin
                    ctrl_a.pop       = s_fire;
                    res.served_class = tcq_pkg::CLASS_A;
                    res.payload      = tcq_pkg::FIELD_W'(head_a[TAG_WIDTH-1:0]);
                    res.stamp        = head_a[ENTRY_W-1:TAG_WIDTH];
                end
            end
            default: begin
                // unused codes: no state change, status ok
            end
        endcase
    end

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (s_fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {res_reg.stamp, res_reg.payload};
    assign m_tuser  = {res_reg.served_class, res_reg.status};

    // checks
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> m_tvalid)
        else $error("accepted command gave no result");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_a <= CNT_W'(QUEUE_DEPTH)) && (count_b <= CNT_W'(QUEUE_DEPTH)))
        else $error("queue count beyond depth");

    a_single_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctrl_a.pop && ctrl_b.pop) && !(ctrl_a.pop && stat_a.empty) &&
        !(ctrl_b.pop && stat_b.empty))
        else $error("bad pop request");

    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl_a.push && stat_a.full) |=> $stable(count_a))
        else $error("dropped insert changed class A count");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tuser)))
        else $error("result changed while stalled");

endmodule
